@@ rtl/core/ppid_pkg.sv @@
// Shared types and constants for the position PID controller.
// Used by ppid_ctrl, ppid_dp and position_pid_with_reverse_offset.
package ppid_pkg;

  localparam int CONTROL_RATE = 1024;

  localparam int GAIN_W    = 16;
  localparam int POS_W     = 32;
  localparam int TICK_W    = 16;
  localparam int DUTY_W    = 32;
  localparam int ERR_W     = 40;
  localparam int PROD_W    = ERR_W + GAIN_W + 1;
  localparam int ACC_W     = PROD_W + 3;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DD = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0] GAIN_P_RST  = GAIN_W'(25000);
  localparam logic [GAIN_W-1:0] GAIN_I_RST  = GAIN_W'(50);
  localparam logic [GAIN_W-1:0] GAIN_D_RST  = GAIN_W'(280);
  localparam logic [GAIN_W-1:0] GAIN_DD_RST = GAIN_W'(0);

  localparam int INTEG_MULT    = 8;
  localparam int DUTY_SHIFT    = 10;
  localparam int REV_SPEED_MIN = 4096;
  localparam int REV_MUL       = 19;
  localparam int REV_SHIFT     = 9;

  // x*99/100: multiply by 99, then floor(n/100) as (n*ceil(2^31/100)) >> 31,
  // exact for n < 2^24.
  localparam int LEAK_NUM     = 99;
  localparam int LEAK_RECIP   = 21474837;
  localparam int LEAK_RECIP_W = 25;
  localparam int LEAK_SHIFT   = 31;

  typedef enum logic [1:0] {
    MAC_P,
    MAC_I,
    MAC_D,
    MAC_DD
  } mac_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     err_en;
    logic     scale_en;
    logic     leak_en;
    logic     diff_en;
    logic     mul_en;
    mac_sel_t mac_sel;
    logic     add_en;
    logic     div_en;
    logic     out_load;
  } ppid_cmd_t;

endpackage

@@ rtl/core/ppid_ctrl.sv @@
// Sequencer for the position PID controller: steps the datapath through
// one control tick and owns the request handshakes. Depends on ppid_pkg.
module ppid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  output logic                out_valid,
  input  logic                out_stall,
  output ppid_pkg::ppid_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SCALE,
    S_LEAK,
    S_DIFF,
    S_MAC,
    S_DIV,
    S_OUT
  } state_t;

  localparam logic [2:0] MAC_LAST = 3'd4;

  state_t     state;
  logic [2:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid && !kind;
    cmd.clear    = (state == S_IDLE) && in_valid && kind;
    cmd.err_en   = (state == S_ERR);
    cmd.scale_en = (state == S_SCALE);
    cmd.leak_en  = (state == S_LEAK);
    cmd.diff_en  = (state == S_DIFF);
    cmd.mul_en   = (state == S_MAC) && (cnt != MAC_LAST);
    cmd.mac_sel  = ppid_pkg::mac_sel_t'(cnt[1:0]);
    cmd.add_en   = (state == S_MAC) && (cnt != 3'd0);
    cmd.div_en   = (state == S_DIV);
    cmd.out_load = (state == S_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_ERR;
          end
        end
        S_ERR:   state <= S_SCALE;
        S_SCALE: state <= S_LEAK;
        S_LEAK:  state <= S_DIFF;
        S_DIFF: begin
          cnt   <= 3'd0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (cnt == MAC_LAST) begin
            state <= S_DIV;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_DIV: state <= S_OUT;
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/ppid_dp.sv @@
// Datapath for the position PID controller: gain registers, error terms,
// leaky integral, shared gain multiplier, duty shaping. Depends on ppid_pkg.
module ppid_dp #(
  parameter int CONTROL_RATE = ppid_pkg::CONTROL_RATE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ppid_pkg::ppid_cmd_t                   cmd,
  input  logic                                  cfg_write,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppid_pkg::GAIN_W-1:0]           cfg_data,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_pos,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_vel,
  input  logic signed [ppid_pkg::POS_W-1:0]     measured_pos,
  input  logic signed [ppid_pkg::TICK_W-1:0]    tick_vel,
  output logic signed [ppid_pkg::DUTY_W-1:0]    duty
);

  localparam int GAIN_W = ppid_pkg::GAIN_W;
  localparam int POS_W  = ppid_pkg::POS_W;
  localparam int ERR_W  = ppid_pkg::ERR_W;
  localparam int PROD_W = ppid_pkg::PROD_W;
  localparam int ACC_W  = ppid_pkg::ACC_W;
  localparam int DUTY_W = ppid_pkg::DUTY_W;

  localparam int MVEL_W = ppid_pkg::TICK_W + 1 + $clog2(CONTROL_RATE);
  localparam int PERR_W = POS_W + 1;
  localparam int LIMIT  = ppid_pkg::INTEG_MULT * CONTROL_RATE;
  localparam int INT_W  = $clog2(LIMIT + 1) + 1;
  localparam int MAG_W  = INT_W - 1;
  localparam int M99_W  = MAG_W + 7;
  localparam int LQ_W   = M99_W + ppid_pkg::LEAK_RECIP_W;
  localparam int SUM_W  = PERR_W + 1;
  localparam int OFF_W  = MVEL_W + 5;
  localparam int DQ_W   = ACC_W - ppid_pkg::DUTY_SHIFT;
  localparam int RD_W   = DQ_W + 1;

  localparam logic signed [SUM_W-1:0] LIMIT_POS = SUM_W'(LIMIT);
  localparam logic signed [SUM_W-1:0] LIMIT_NEG = -SUM_W'(LIMIT);
  localparam logic signed [ACC_W-1:0] DIV_BIAS  = ACC_W'((1 << ppid_pkg::DUTY_SHIFT) - 1);
  localparam logic signed [RD_W-1:0]  DUTY_MAX  = RD_W'(32'sh7fffffff);
  localparam logic signed [RD_W-1:0]  DUTY_MIN  = -RD_W'(64'sh80000000);

  logic [GAIN_W-1:0] gain_p, gain_i, gain_d, gain_dd;

  logic signed [POS_W-1:0]            tpos, tvel, mpos;
  logic signed [ppid_pkg::TICK_W-1:0] tick;
  logic signed [PERR_W-1:0]           pos_err;
  logic signed [MVEL_W-1:0]           mvel;
  logic signed [ERR_W-1:0]            vel_err, vel_delta, vel_delta2;
  logic signed [ERR_W-1:0]            prev_vel_error, prev_vel_error_delta;
  logic signed [INT_W-1:0]            integral;
  logic                               leak_neg;
  logic [M99_W-1:0]                   m99;
  logic [MAG_W-1:0]                   leak_q;
  logic signed [PROD_W-1:0]           prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [DQ_W-1:0]             duty_q;
  logic                               rev_big;
  logic [OFF_W-1:0]                   offset;

  // Combinational helpers
  logic [MAG_W-1:0]                   int_mag;
  logic [LQ_W-1:0]                    leak_prod;
  logic signed [SUM_W-1:0]            leak_s, integ_sum, integ_next;
  logic [MVEL_W-1:0]                  speed;
  logic signed [GAIN_W:0]             mul_a;
  logic signed [ERR_W-1:0]            mul_b;
  logic signed [ACC_W-1:0]            acc_adj;
  logic signed [RD_W-1:0]             dq_ext, off_ext, rev_res, duty_next;
  logic                               rev_apply;

  assign int_mag   = MAG_W'(integral[INT_W-1] ? -integral : integral);
  assign leak_prod = LQ_W'(m99) * LQ_W'(ppid_pkg::LEAK_RECIP);
  assign leak_s    = leak_neg ? -SUM_W'({1'b0, leak_q}) : SUM_W'({1'b0, leak_q});
  assign integ_sum = SUM_W'(pos_err) + leak_s;

  always_comb begin
    if (integ_sum > LIMIT_POS) begin
      integ_next = LIMIT_POS;
    end else if (integ_sum < LIMIT_NEG) begin
      integ_next = LIMIT_NEG;
    end else begin
      integ_next = integ_sum;
    end
  end

  assign speed = MVEL_W'(mvel[MVEL_W-1] ? -mvel : mvel);

  always_comb begin
    case (cmd.mac_sel)
      ppid_pkg::MAC_P: begin
        mul_a = $signed({1'b0, gain_p});
        mul_b = ERR_W'(pos_err);
      end
      ppid_pkg::MAC_I: begin
        mul_a = $signed({1'b0, gain_i});
        mul_b = ERR_W'(integral);
      end
      ppid_pkg::MAC_D: begin
        mul_a = $signed({1'b0, gain_d});
        mul_b = vel_err;
      end
      default: begin
        mul_a = $signed({1'b0, gain_dd});
        mul_b = vel_delta2;
      end
    endcase
  end

  assign acc_adj = acc + (acc[ACC_W-1] ? DIV_BIAS : '0);

  // Reverse-drive offset, never flipping the duty sign
  assign dq_ext    = RD_W'(duty_q);
  assign off_ext   = $signed(RD_W'(offset));
  assign rev_apply = (duty_q != '0) && rev_big && (mvel[MVEL_W-1] != duty_q[DQ_W-1]);

  always_comb begin
    if (!duty_q[DQ_W-1]) begin
      rev_res = dq_ext - off_ext;
      if (rev_res <= RD_W'(0)) begin
        rev_res = RD_W'(1);
      end
    end else begin
      rev_res = dq_ext + off_ext;
      if (rev_res >= RD_W'(0)) begin
        rev_res = -RD_W'(1);
      end
    end
  end

  always_comb begin
    duty_next = rev_apply ? rev_res : dq_ext;
    if (duty_next > DUTY_MAX) begin
      duty_next = DUTY_MAX;
    end else if (duty_next < DUTY_MIN) begin
      duty_next = DUTY_MIN;
    end
  end

  // Gain registers and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p               <= ppid_pkg::GAIN_P_RST;
      gain_i               <= ppid_pkg::GAIN_I_RST;
      gain_d               <= ppid_pkg::GAIN_D_RST;
      gain_dd              <= ppid_pkg::GAIN_DD_RST;
      integral             <= '0;
      prev_vel_error       <= '0;
      prev_vel_error_delta <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ppid_pkg::REG_GAIN_P:  gain_p  <= cfg_data;
          ppid_pkg::REG_GAIN_I:  gain_i  <= cfg_data;
          ppid_pkg::REG_GAIN_D:  gain_d  <= cfg_data;
          ppid_pkg::REG_GAIN_DD: gain_dd <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        integral       <= '0;
        prev_vel_error <= '0;
      end
      if (cmd.leak_en) begin
        integral       <= INT_W'(integ_next);
        prev_vel_error <= vel_err;
      end
      if (cmd.diff_en) begin
        prev_vel_error_delta <= vel_delta;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tpos <= target_pos;
      tvel <= target_vel;
      mpos <= measured_pos;
      tick <= tick_vel;
    end
    if (cmd.err_en) begin
      pos_err  <= PERR_W'(tpos) - PERR_W'(mpos);
      mvel     <= MVEL_W'(tick) * $signed(MVEL_W'(CONTROL_RATE));
      m99      <= M99_W'(int_mag) * M99_W'(ppid_pkg::LEAK_NUM);
      leak_neg <= integral[INT_W-1];
    end
    if (cmd.scale_en) begin
      vel_err <= ERR_W'(tvel) - ERR_W'(mvel);
      leak_q  <= MAG_W'(leak_prod >> ppid_pkg::LEAK_SHIFT);
    end
    if (cmd.leak_en) begin
      vel_delta <= vel_err - prev_vel_error;
    end
    if (cmd.diff_en) begin
      vel_delta2 <= vel_delta - prev_vel_error_delta;
      rev_big    <= (speed > MVEL_W'(ppid_pkg::REV_SPEED_MIN));
      offset     <= (OFF_W'(speed) * OFF_W'(ppid_pkg::REV_MUL)) >> ppid_pkg::REV_SHIFT;
      acc        <= '0;
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.add_en) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.div_en) begin
      duty_q <= DQ_W'(acc_adj >>> ppid_pkg::DUTY_SHIFT);
    end
    if (cmd.out_load) begin
      duty <= DUTY_W'(duty_next);
    end
  end

endmodule

@@ rtl/core/position_pid_with_reverse_offset.sv @@
// Position PID controller with leaky integral and reverse-drive offset.
// Sequencer steps a control tick request through S_ERR, S_SCALE, S_LEAK, S_DIFF,
// S_MAC, S_DIV and S_OUT, sharing one gain multiplier over four terms, and takes no
// new request until its duty is loaded (out_stall can hold that); a clear gives no result.
// Reset (rst, synchronous): gains to defaults, integral and velocity history
// zeroed, both channels idle. Depends on ppid_pkg, ppid_ctrl, ppid_dp.
module position_pid_with_reverse_offset #(
  parameter int CONTROL_RATE = ppid_pkg::CONTROL_RATE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppid_pkg::GAIN_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_pos,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_vel,
  input  logic signed [ppid_pkg::POS_W-1:0]     measured_pos,
  input  logic signed [ppid_pkg::TICK_W-1:0]    tick_vel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ppid_pkg::DUTY_W-1:0]    duty
);

  ppid_pkg::ppid_cmd_t cmd;

  ppid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ppid_dp #(
    .CONTROL_RATE (CONTROL_RATE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .target_pos   (target_pos),
    .target_vel   (target_vel),
    .measured_pos (measured_pos),
    .tick_vel     (tick_vel),
    .duty         (duty)
  );

endmodule

@@ verif/position_pid_with_reverse_offset_chk.sv @@
`timescale 1ns / 1ps
// Checker for position_pid_with_reverse_offset: watches config, request and result
// channels, predicts each duty and compares it in order. Depends on ppid_pkg.
module position_pid_with_reverse_offset_chk (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppid_pkg::GAIN_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  kind,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_pos,
  input  logic signed [ppid_pkg::POS_W-1:0]     target_vel,
  input  logic signed [ppid_pkg::POS_W-1:0]     measured_pos,
  input  logic signed [ppid_pkg::TICK_W-1:0]    tick_vel,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [ppid_pkg::DUTY_W-1:0]    duty,
  output int                                    errors,
  output int                                    pending
);

  localparam int GAIN_W = ppid_pkg::GAIN_W;
  localparam int POS_W  = ppid_pkg::POS_W;
  localparam int TICK_W = ppid_pkg::TICK_W;
  localparam int DUTY_W = ppid_pkg::DUTY_W;

  localparam longint DUTY_DIV  = longint'(1) << ppid_pkg::DUTY_SHIFT;
  localparam longint INTEG_MAX = longint'(ppid_pkg::INTEG_MULT) * ppid_pkg::CONTROL_RATE;
  localparam longint DUTY_MAX  = (longint'(1) << (DUTY_W - 1)) - 1;
  localparam longint DUTY_MIN  = -(longint'(1) << (DUTY_W - 1));

  logic [GAIN_W-1:0] kp, ki, kd, kdd;
  longint integ_acc;
  longint last_vel_err;
  longint last_vel_delta;

  logic signed [DUTY_W-1:0] duty_q[$];

  function automatic int sign_of(input longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  // Advances the controller state by one tick and returns the duty it drives.
  function automatic logic signed [DUTY_W-1:0] next_duty(
    input logic signed [POS_W-1:0]  tpos,
    input logic signed [POS_W-1:0]  tvel,
    input logic signed [POS_W-1:0]  mpos,
    input logic signed [TICK_W-1:0] tvel_tick
  );
    longint mvel, pos_err, vel_err, vel_delta, vel_delta2, acc, sum, speed, offset;
    mvel       = longint'(tvel_tick) * ppid_pkg::CONTROL_RATE;
    pos_err    = longint'(tpos) - longint'(mpos);
    vel_err    = longint'(tvel) - mvel;
    vel_delta  = vel_err - last_vel_err;
    vel_delta2 = vel_delta - last_vel_delta;
    last_vel_delta = vel_delta;
    last_vel_err   = vel_err;

    acc = integ_acc * ppid_pkg::LEAK_NUM / 100 + pos_err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    else if (acc < -INTEG_MAX) acc = -INTEG_MAX;
    integ_acc = acc;

    sum = (longint'(kp) * pos_err + longint'(ki) * integ_acc
           + longint'(kd) * vel_err + longint'(kdd) * vel_delta2) / DUTY_DIV;

    if (sum != 0) begin
      speed = mvel < 0 ? -mvel : mvel;
      if (speed > ppid_pkg::REV_SPEED_MIN && sign_of(mvel) != sign_of(sum)) begin
        offset = (speed * ppid_pkg::REV_MUL) >> ppid_pkg::REV_SHIFT;
        if (sum > 0) begin
          sum = (sum - offset > 0) ? sum - offset : 1;
        end else begin
          sum = (sum + offset < 0) ? sum + offset : -1;
        end
      end
    end

    if (sum > DUTY_MAX) sum = DUTY_MAX;
    else if (sum < DUTY_MIN) sum = DUTY_MIN;
    return sum[DUTY_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [DUTY_W-1:0] want;
    if (rst) begin
      kp  = ppid_pkg::GAIN_P_RST;
      ki  = ppid_pkg::GAIN_I_RST;
      kd  = ppid_pkg::GAIN_D_RST;
      kdd = ppid_pkg::GAIN_DD_RST;
      integ_acc      = 0;
      last_vel_err   = 0;
      last_vel_delta = 0;
      duty_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_q.size() == 0) begin
          $error("duty: expected none, actual %0d", duty);
          errors <= errors + 1;
        end else begin
          want = duty_q.pop_front();
          if (want !== duty) begin
            $error("duty: expected %0d, actual %0d", want, duty);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          ppid_pkg::REG_GAIN_P:  kp  = cfg_data;
          ppid_pkg::REG_GAIN_I:  ki  = cfg_data;
          ppid_pkg::REG_GAIN_D:  kd  = cfg_data;
          ppid_pkg::REG_GAIN_DD: kdd = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (kind) begin
          integ_acc    = 0;
          last_vel_err = 0;
        end else begin
          duty_q.push_back(next_duty(target_pos, target_vel, measured_pos, tick_vel));
        end
      end
    end
    pending <= duty_q.size();
  end

endmodule

@@ verif/position_pid_with_reverse_offset_tb.sv @@
`timescale 1ns / 1ps
// Top testbench for position_pid_with_reverse_offset: drives config and bursty tick
// requests, stalls results, and reports the checker's verdict. Depends on ppid_pkg.
module position_pid_with_reverse_offset_tb;

  localparam int GAIN_W       = ppid_pkg::GAIN_W;
  localparam int CFG_IDX_W    = ppid_pkg::CFG_IDX_W;
  localparam int POS_W        = ppid_pkg::POS_W;
  localparam int TICK_W       = ppid_pkg::TICK_W;
  localparam int DUTY_W       = ppid_pkg::DUTY_W;
  localparam int CONTROL_RATE = ppid_pkg::CONTROL_RATE;

  typedef struct {
    logic                     k;
    logic signed [POS_W-1:0]  tp;
    logic signed [POS_W-1:0]  tv;
    logic signed [POS_W-1:0]  mp;
    logic signed [TICK_W-1:0] tk;
  } tick_req_t;

  localparam int P_MAX = 32'sh7fffffff;
  localparam int P_MIN = 32'sh80000000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [GAIN_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = 1'b0;
  logic signed [POS_W-1:0]  target_pos = '0;
  logic signed [POS_W-1:0]  target_vel = '0;
  logic signed [POS_W-1:0]  measured_pos = '0;
  logic signed [TICK_W-1:0] tick_vel = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DUTY_W-1:0] duty;
  int                       errors;
  int                       pending;

  int burst_left = 1;
  int gap_max = 4;
  int stall_mode = 0;
  int stall_cyc = 0;

  position_pid_with_reverse_offset i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .target_pos(target_pos), .target_vel(target_vel),
    .measured_pos(measured_pos), .tick_vel(tick_vel),
    .out_valid(out_valid), .out_stall(out_stall), .duty(duty)
  );

  position_pid_with_reverse_offset_chk i_chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .target_pos(target_pos), .target_vel(target_vel),
    .measured_pos(measured_pos), .tick_vel(tick_vel),
    .out_valid(out_valid), .out_stall(out_stall), .duty(duty),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result stall pattern, switching among four styles at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 200 == 199) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= (stall_cyc % 23) < 15;
      endcase
    end
  end

  function automatic tick_req_t mk(input logic k, input int tp, input int tv,
                                   input int mp, input int tk);
    tick_req_t r;
    r.k  = k;
    r.tp = tp;
    r.tv = tv;
    r.mp = mp;
    r.tk = TICK_W'(tk);
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] edge32();
    case ($urandom_range(0, 4))
      0: return P_MIN;
      1: return P_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tick_req_t rand_req();
    tick_req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    r.k = ($urandom_range(0, 15) == 0);
    if (sel < 2) begin
      r.tp = $urandom;
      r.tv = $urandom;
      r.mp = $urandom;
      r.tk = TICK_W'($urandom);
    end else if (sel < 9) begin
      r.tk = TICK_W'(int'($urandom_range(0, 400)) - 200);
      r.mp = $urandom;
      r.tp = r.mp + (int'($urandom_range(0, 6000)) - 3000);
      r.tv = int'(r.tk) * CONTROL_RATE + int'($urandom_range(0, 8000)) - 4000;
    end else begin
      r.tp = edge32();
      r.tv = edge32();
      r.mp = edge32();
      case ($urandom_range(0, 3))
        0: r.tk = 16'sh8000;
        1: r.tk = 16'sh7fff;
        2: r.tk = '0;
        default: r.tk = TICK_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic send_req(input tick_req_t r);
    kind         <= r.k;
    target_pos   <= r.tp;
    target_vel   <= r.tv;
    measured_pos <= r.mp;
    tick_vel     <= r.tk;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // drain all expected duties plus a margin for a trailing clear
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                           input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] dd,
                           input int n, input int gap);
    settle();
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), GAIN_W'($urandom));
    write_reg(ppid_pkg::REG_GAIN_P, p);
    write_reg(ppid_pkg::REG_GAIN_I, i);
    write_reg(ppid_pkg::REG_GAIN_D, d);
    write_reg(ppid_pkg::REG_GAIN_DD, dd);
    cfg_write <= 1'b0;
    gap_max = gap;
    burst_left = 1;
    repeat (n) send_req(rand_req());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks at reset gains
    send_req(mk(1'b1, $urandom, $urandom, $urandom, $urandom));
    send_req(mk(1'b0, 0, 0, 0, 0));
    send_req(mk(1'b0, P_MAX, 0, P_MIN, 0));
    send_req(mk(1'b0, P_MIN, 0, P_MAX, 0));
    send_req(mk(1'b1, 0, 0, 0, 0));
    send_req(mk(1'b0, 1, -5120, 0, -5));
    send_req(mk(1'b0, -1, 5120, 0, 5));
    send_req(mk(1'b0, 1, 4096, 0, 4));
    send_req(mk(1'b0, 1, -4096, 0, -4));
    send_req(mk(1'b0, 1000, -20480, 0, -20));
    send_req(mk(1'b0, -1000, 20480, 0, 20));
    send_req(mk(1'b0, $urandom, P_MAX, $urandom, 16'sh7fff));
    send_req(mk(1'b0, $urandom, P_MIN, $urandom, 16'sh8000));
    send_req(mk(1'b0, 0, P_MIN, 0, 16'sh7fff));
    send_req(mk(1'b0, 0, P_MAX, 0, 16'sh8000));
    send_req(mk(1'b0, -1, -1, -1, -1));
    send_req(mk(1'b1, -1, -1, -1, -1));
    send_req(mk(1'b0, 123, -102400, 123, -100));
    send_req(mk(1'b0, P_MAX, P_MAX, P_MAX, 16'sh7fff));

    run_phase('1, '1, '1, '1, 100, 15);
    run_phase('0, '0, '0, '0, 60, 0);
    run_phase(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
              GAIN_W'($urandom), 120, 15);
    run_phase(GAIN_W'($urandom_range(0, 300)), GAIN_W'($urandom_range(0, 300)),
              GAIN_W'($urandom_range(0, 300)), GAIN_W'($urandom_range(1, 300)), 120, 6);
    run_phase(ppid_pkg::GAIN_P_RST, ppid_pkg::GAIN_I_RST, ppid_pkg::GAIN_D_RST,
              GAIN_W'($urandom), 100, 15);
    settle();

    if (errors == 0) begin
      $display("position_pid_with_reverse_offset: match");
    end else begin
      $display("position_pid_with_reverse_offset: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("position_pid_with_reverse_offset: mismatch");
    $finish;
  end

endmodule
